@@ hw/rtl/tbs_pkg.sv @@
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, codes and helpers for the toroidal 3x3 box smoothing unit.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;
  localparam int COORD_W    = 8;
  localparam int HEIGHT_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam int DIVISOR = 9;

  localparam logic [1:0] SEL_LO  = 2'd0;
  localparam logic [1:0] SEL_MID = 2'd1;
  localparam logic [1:0] SEL_HI  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } tbs_state_e;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                   input logic [10:0] limit);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if ({2'b00, v} > limit) begin
      r = limit[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tbs_ram.sv @@
// ----------------------------------------------------------------------------
// tbs_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module tbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tbs_div9.sv @@
// ----------------------------------------------------------------------------
// tbs_div9
// Unsigned division by nine through a reciprocal multiply; start is registered
// into a busy flag and then into done, and the quotient is registered while busy.
// ----------------------------------------------------------------------------
module tbs_div9 #(
  parameter int WIDTH = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);
  import tbs_pkg::*;

  // ceil(2^SHIFT / 9); exact floor for every dividend below 2^WIDTH
  localparam int SHIFT  = WIDTH + 3;
  localparam int PROD_W = 2 * WIDTH;
  localparam logic [WIDTH-1:0] RECIP =
    WIDTH'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

  logic [WIDTH-1:0]  dvd_q;
  logic [WIDTH-1:0]  quot_q, quot_d;
  logic              busy_q, done_q;
  logic [PROD_W-1:0] prod;

  assign prod   = PROD_W'(dvd_q) * PROD_W'(RECIP);
  assign quot_d = WIDTH'(prod[PROD_W-1:SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (busy_q) begin
      quot_q <= quot_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

@@ hw/rtl/toroidal_box_smoothing_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// toroidal_box_smoothing_3x3_unit
// Height map store with wraparound 3x3 mean readout.
//
//   channel | direction | words                      | handshake
//   --------+-----------+----------------------------+--------------------
//   in      | input     | action, col, row, height_in | in_valid_i/in_stall_o
//   out     | output    | smoothed, status           | out_valid_o/out_stall_i
//   cfg     | input     | map_width, map_height      | cfg_we_i
//
// A write or out-of-range word goes straight to the done state. A read word makes
// nine fetches through the single RAM port, one accumulate step and the
// reciprocal multiply by one ninth. One word in flight; the output register
// lets the next word enter while a result is stalled. No clearing pass after reset.
// ----------------------------------------------------------------------------
module toroidal_box_smoothing_3x3_unit #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [tbs_pkg::COORD_W-1:0]   col_i,
  input  logic [tbs_pkg::COORD_W-1:0]   row_i,
  input  logic signed [tbs_pkg::HEIGHT_W-1:0] height_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [tbs_pkg::HEIGHT_W-1:0] smoothed_o,
  output logic                          status_o,
  input  logic                          cfg_we_i,
  input  logic [tbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tbs_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = ADDR_W + SIZE_W;
  localparam int ACC_W  = SAMPLE_BITS + 4;
  localparam logic [SIZE_W-1:0] RST_W = SIZE_W'((MAX_COLS < 256) ? MAX_COLS : 256);
  localparam logic [SIZE_W-1:0] RST_H = SIZE_W'((MAX_ROWS < 256) ? MAX_ROWS : 256);

  tbs_state_e state_q, state_d;

  logic [SIZE_W-1:0] map_width_q, map_height_q;
  logic [SIZE_W-1:0] cl_q, cc_q, cr_q, ru_q, rc_q, rd_q;
  logic [1:0]        csel_q, rsel_q;
  logic              rd_vld_q;
  logic [ACC_W-1:0]  acc_q;
  logic signed [HEIGHT_W-1:0] res_smoothed_q, out_smoothed_q;
  logic              res_status_q, out_status_q, out_valid_q;

  logic              accept, err, out_free, last_fetch;
  logic [SIZE_W-1:0] col_ext, row_ext, cl_w, cr_w, ru_w, rd_w;
  logic [SIZE_W-1:0] col_sel, row_sel;
  logic [PROD_W-1:0] in_prod, nb_prod;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;
  logic [ACC_W-1:0]  biased, acc_sum;
  logic [ACC_W-1:0]  quotient;
  logic [SAMPLE_BITS-1:0] q_sb;
  logic signed [HEIGHT_W-1:0] mean_w;
  logic              div_start, div_done;

  // Coordinates and wrapped neighbors
  assign col_ext = {1'b0, col_i};
  assign row_ext = {1'b0, row_i};
  assign err     = (col_ext >= map_width_q) || (row_ext >= map_height_q);
  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign cl_w = (col_i == '0) ? map_width_q - SIZE_W'(1) : col_ext - SIZE_W'(1);
  assign cr_w = (col_ext + SIZE_W'(1) >= map_width_q) ? '0 : col_ext + SIZE_W'(1);
  assign ru_w = (row_i == '0) ? map_height_q - SIZE_W'(1) : row_ext - SIZE_W'(1);
  assign rd_w = (row_ext + SIZE_W'(1) >= map_height_q) ? '0 : row_ext + SIZE_W'(1);

  always_comb begin
    case (csel_q)
      SEL_LO:  col_sel = cl_q;
      SEL_MID: col_sel = cc_q;
      default: col_sel = cr_q;
    endcase
    case (rsel_q)
      SEL_LO:  row_sel = ru_q;
      SEL_MID: row_sel = rc_q;
      default: row_sel = rd_q;
    endcase
  end

  assign in_prod    = PROD_W'(row_ext) * PROD_W'(MAX_COLS) + PROD_W'(col_ext);
  assign nb_prod    = PROD_W'(row_sel) * PROD_W'(MAX_COLS) + PROD_W'(col_sel);
  assign last_fetch = (csel_q == SEL_HI) && (rsel_q == SEL_HI);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_wdata  = SAMPLE_BITS'(height_in_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (err || action_i == ACT_WRITE) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (last_fetch) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_addr   = nb_prod[ADDR_W-1:0];
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_addr   = in_prod[ADDR_W-1:0];
        mem_we     = in_valid_i && !err && (action_i == ACT_WRITE);
      end
      ST_SUM:  div_start = 1'b1;
      default: ;
    endcase
  end

  // Accumulate biased samples so the divider sees an unsigned sum
  assign biased  = ACC_W'({~mem_rdata[SAMPLE_BITS-1], mem_rdata[SAMPLE_BITS-2:0]});
  assign acc_sum = acc_q + biased;
  assign q_sb    = {~quotient[SAMPLE_BITS-1], quotient[SAMPLE_BITS-2:0]};
  assign mean_w  = HEIGHT_W'($signed(q_sb));

  tbs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  tbs_div9 #(
    .WIDTH (ACC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_sum),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      map_width_q  <= RST_W;
      map_height_q <= RST_H;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_FETCH);
      if (cfg_we_i && cfg_index_i == REG_MAP_WIDTH) begin
        map_width_q <= clamp_size(cfg_data_i, 11'(MAX_COLS));
      end
      if (cfg_we_i && cfg_index_i == REG_MAP_HEIGHT) begin
        map_height_q <= clamp_size(cfg_data_i, 11'(MAX_ROWS));
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cl_q   <= cl_w;
      cc_q   <= col_ext;
      cr_q   <= cr_w;
      ru_q   <= ru_w;
      rc_q   <= row_ext;
      rd_q   <= rd_w;
      csel_q <= SEL_LO;
      rsel_q <= SEL_LO;
      acc_q  <= '0;
      res_smoothed_q <= '0;
      res_status_q   <= err ? STATUS_RANGE : STATUS_OK;
    end else begin
      if (state_q == ST_FETCH) begin
        if (csel_q == SEL_HI) begin
          csel_q <= SEL_LO;
          rsel_q <= rsel_q + 2'd1;
        end else begin
          csel_q <= csel_q + 2'd1;
        end
      end
      if (rd_vld_q) begin
        acc_q <= acc_sum;
      end
      if (state_q == ST_DIV && div_done) begin
        res_smoothed_q <= mean_w;
        res_status_q   <= STATUS_OK;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_smoothed_q <= res_smoothed_q;
      out_status_q   <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_smoothed_q;
  assign status_o    = out_status_q;

endmodule

@@ tb/toroidal_box_smoothing_3x3_unit_test.sv @@
// ----------------------------------------------------------------------------
// toroidal_box_smoothing_3x3_unit_test
// Self-checking bench for the wraparound 3x3 height map smoothing unit.
//
// A queue-fed driver offers write, read and out-of-range words with random
// gaps. A clocked monitor applies random stalls and compares every result
// against an in-bench model of the height store. The map size is changed
// between phases, including sizes of one and saturated sizes. Reads are only
// issued once all nine cells around the target hold written heights.
// ----------------------------------------------------------------------------
module toroidal_box_smoothing_3x3_unit_test;
  import tbs_pkg::*;

  localparam int MAP_SPAN    = 256;
  localparam int HOOD_CELLS  = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_OPS   = 68;
  localparam int N_PHASES    = 9;

  typedef struct {
    logic                       action;
    logic [COORD_W-1:0]         col;
    logic [COORD_W-1:0]         row;
    logic signed [HEIGHT_W-1:0] height;
  } cell_op_t;

  typedef struct {
    logic signed [HEIGHT_W-1:0] mean;
    logic                       status;
  } smooth_out_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic                       action_i    = ACT_WRITE;
  logic [COORD_W-1:0]         col_i       = '0;
  logic [COORD_W-1:0]         row_i       = '0;
  logic signed [HEIGHT_W-1:0] height_in_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [HEIGHT_W-1:0] smoothed_o;
  logic                       status_o;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = REG_MAP_WIDTH;
  logic [CFG_DATA_W-1:0]      cfg_data_i  = '0;

  logic signed [HEIGHT_W-1:0] height_model [MAP_SPAN*MAP_SPAN];
  bit                         cell_written [MAP_SPAN*MAP_SPAN];
  int                         cfg_cols = MAP_SPAN;
  int                         cfg_rows = MAP_SPAN;

  cell_op_t    cell_ops_q [$];
  smooth_out_t smoothed_q [$];
  cell_op_t    tx_op;
  smooth_out_t rx_want;

  int tx_wait;
  int rx_wait;
  int tx_gap_max   = 0;
  int rx_stall_max = 0;
  int rx_hold_left = 0;

  int ops_queued      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int n_writes        = 0;
  int n_reads         = 0;
  int n_range         = 0;
  int sizes_run       = 0;
  int cycle_count     = 0;

  toroidal_box_smoothing_3x3_unit u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic int fit_size(input int raw);
    int v;
    v = raw & 'h1FF;
    if (v == 0) return 1;
    if (v > MAP_SPAN) return MAP_SPAN;
    return v;
  endfunction

  function automatic int wrap_dn(input int v, input int n);
    return (v == 0) ? n - 1 : v - 1;
  endfunction

  function automatic int wrap_up(input int v, input int n);
    return (v + 1 >= n) ? 0 : v + 1;
  endfunction

  function automatic int pick_coord(input int n);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  function automatic logic [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic bit hood_written(input int c, input int r);
    int xs[3];
    int ys[3];
    xs = '{wrap_dn(c, cfg_cols), c, wrap_up(c, cfg_cols)};
    ys = '{wrap_dn(r, cfg_rows), r, wrap_up(r, cfg_rows)};
    foreach (ys[j]) foreach (xs[i]) if (!cell_written[ys[j]*MAP_SPAN + xs[i]]) return 1'b0;
    return 1'b1;
  endfunction

  // model of the unit: update the store and queue the result for one word
  task automatic box_mean_step(input logic act, input logic [COORD_W-1:0] c,
                               input logic [COORD_W-1:0] r,
                               input logic signed [HEIGHT_W-1:0] h);
    smooth_out_t res;
    int          xs[3];
    int          ys[3];
    int          sum;
    int          mean_v;
    res.mean   = '0;
    res.status = STATUS_OK;
    if (int'(c) >= cfg_cols || int'(r) >= cfg_rows) begin
      res.status = STATUS_RANGE;
      n_range++;
    end else if (act == ACT_WRITE) begin
      height_model[int'(r)*MAP_SPAN + int'(c)] = h;
      n_writes++;
    end else begin
      xs  = '{wrap_dn(int'(c), cfg_cols), int'(c), wrap_up(int'(c), cfg_cols)};
      ys  = '{wrap_dn(int'(r), cfg_rows), int'(r), wrap_up(int'(r), cfg_rows)};
      sum = 0;
      foreach (ys[j]) foreach (xs[i]) sum += height_model[ys[j]*MAP_SPAN + xs[i]];
      mean_v = sum / HOOD_CELLS;
      if (sum % HOOD_CELLS != 0 && sum < 0) mean_v--;
      res.mean = HEIGHT_W'(mean_v);
      n_reads++;
    end
    smoothed_q.push_back(res);
  endtask

  task automatic queue_cell_op(input logic act, input int c, input int r,
                               input logic [HEIGHT_W-1:0] h);
    cell_op_t op;
    op.action = act;
    op.col    = COORD_W'(c);
    op.row    = COORD_W'(r);
    op.height = h;
    if (act == ACT_WRITE && c < cfg_cols && r < cfg_rows) cell_written[r*MAP_SPAN + c] = 1'b1;
    cell_ops_q.push_back(op);
    ops_queued++;
  endtask

  // fill the 3x3 around (c, r), partly reusing old heights, then read it
  task automatic queue_hood_read(input int c, input int r);
    int xs[3];
    int ys[3];
    xs = '{wrap_dn(c, cfg_cols), c, wrap_up(c, cfg_cols)};
    ys = '{wrap_dn(r, cfg_rows), r, wrap_up(r, cfg_rows)};
    foreach (ys[j]) foreach (xs[i])
      if (!cell_written[ys[j]*MAP_SPAN + xs[i]] || $urandom_range(0, 1))
        queue_cell_op(ACT_WRITE, xs[i], ys[j], rand_height());
    queue_cell_op(ACT_READ, c, r, rand_height());
  endtask

  task automatic queue_random_phase(input int n_ops);
    int first;
    int c;
    int r;
    int pick;
    first = ops_queued;
    while (ops_queued - first < n_ops) begin
      pick = $urandom_range(0, 99);
      c    = pick_coord(cfg_cols);
      r    = pick_coord(cfg_rows);
      if (pick < 50) begin
        queue_hood_read(c, r);
      end else if (pick < 70) begin
        if (hood_written(c, r)) queue_cell_op(ACT_READ, c, r, rand_height());
        else queue_hood_read(c, r);
      end else if (pick < 85 || (cfg_cols == MAP_SPAN && cfg_rows == MAP_SPAN)) begin
        queue_cell_op(ACT_WRITE, c, r, rand_height());
      end else if (cfg_cols < MAP_SPAN && (cfg_rows == MAP_SPAN || $urandom_range(0, 1))) begin
        queue_cell_op(1'($urandom_range(0, 1)), $urandom_range(cfg_cols, MAP_SPAN - 1),
                      $urandom_range(0, MAP_SPAN - 1), rand_height());
      end else begin
        queue_cell_op(1'($urandom_range(0, 1)), $urandom_range(0, MAP_SPAN - 1),
                      $urandom_range(cfg_rows, MAP_SPAN - 1), rand_height());
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int raw);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(raw);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_MAP_WIDTH) cfg_cols = fit_size(raw);
    else cfg_rows = fit_size(raw);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cell_ops_q.size() != 0 || in_valid_i || smoothed_q.size() != 0);
  endtask

  task automatic set_map_size(input int raw_w, input int raw_h);
    wait_drained();
    write_reg(REG_MAP_WIDTH, raw_w);
    write_reg(REG_MAP_HEIGHT, raw_h);
    @(negedge clk_i);
    sizes_run++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) box_mean_step(action_i, col_i, row_i, height_in_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (cell_ops_q.size() != 0) begin
          tx_op = cell_ops_q.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= tx_op.action;
          col_i       <= tx_op.col;
          row_i       <= tx_op.row;
          height_in_i <= tx_op.height;
          tx_wait = $urandom_range(0, tx_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (smoothed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: smoothed %0d status %0d", smoothed_o, status_o);
        end else begin
          rx_want = smoothed_q.pop_front();
          if (smoothed_o !== rx_want.mean || status_o !== rx_want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: smoothed exp %0d got %0d, status exp %0d got %0d",
                       results_checked, rx_want.mean, smoothed_o, rx_want.status, status_o);
          end
        end
        results_checked++;
        rx_wait = $urandom_range(0, rx_stall_max);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase_w [N_PHASES];
    int phase_h [N_PHASES];
    int target;
    phase_w = '{511, 3, 1, 256, 2, 300, 40, 0, 256};
    phase_h = '{511, 5, 256, 1, 2, 17, 9, 0, 256};
    foreach (height_model[i]) height_model[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // wrap all four ways around the origin at full size, then a negative floor
    tx_gap_max   = 10;
    rx_stall_max = 10;
    sizes_run    = 1;
    for (int y = -1; y <= 1; y++)
      for (int x = -1; x <= 1; x++)
        queue_cell_op(ACT_WRITE, (x + MAP_SPAN) % MAP_SPAN, (y + MAP_SPAN) % MAP_SPAN, 16'h8000);
    queue_cell_op(ACT_READ, 0, 0, 16'hFFFF);
    queue_cell_op(ACT_WRITE, 255, 255, 16'h7FFF);
    queue_cell_op(ACT_WRITE, 1, 1, 16'h7FFF);
    queue_cell_op(ACT_READ, 0, 0, 16'h0000);

    // zero sizes clamp to a single cell that is its own neighbor
    set_map_size(0, 0);
    queue_cell_op(ACT_WRITE, 0, 0, 16'h7FFF);
    queue_cell_op(ACT_READ, 0, 0, 16'h0000);
    queue_cell_op(ACT_WRITE, 1, 0, 16'hFFFF);
    queue_cell_op(ACT_READ, 0, 1, 16'h0000);
    queue_cell_op(ACT_WRITE, 255, 255, 16'h8000);
    queue_cell_op(ACT_READ, 0, 0, 16'h0000);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 7) begin
        phase_w[p] = $urandom_range(1, 300);
        phase_h[p] = $urandom_range(1, 300);
      end
      set_map_size(phase_w[p], phase_h[p]);
      tx_gap_max   = (p == 0 || p % 3 == 1) ? 0 : 10;
      rx_stall_max = (p == 0 || p % 4 == 2) ? 0 : 10;
      queue_random_phase(PHASE_OPS);
      if (p == 1) begin
        target = results_checked + 8;
        while (results_checked < target) @(negedge clk_i);
        rx_hold_left = 300;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d writes, %0d wrapped 3x3 reads, %0d out-of-range words", n_writes,
             n_reads, n_range);
    $display("over %0d map sizes; %0d results checked, %0d mismatches, %0d cycles",
             sizes_run, results_checked, mismatches, cycle_count);
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
